// ----- rtl/stalloc_pkg.sv -----
package stalloc_pkg;

    // One table record, id in the low bits
    typedef struct packed {
        logic [15:0] pgcnt;
        logic [15:0] pgoff;
        logic [15:0] version;
        logic [15:0] id;
    } entry_t;

    // Request kinds
    localparam logic [2:0] REQ_GET    = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_GETVER = 3'd2;
    localparam logic [2:0] REQ_SETVER = 3'd3;
    localparam logic [2:0] REQ_LIST   = 3'd4;

    // Result status codes
    localparam logic [2:0] STAT_FOUND    = 3'd0;
    localparam logic [2:0] STAT_ALLOC    = 3'd1;
    localparam logic [2:0] STAT_VERSION  = 3'd2;
    localparam logic [2:0] STAT_SIZE     = 3'd3;
    localparam logic [2:0] STAT_NOSPACE  = 3'd4;
    localparam logic [2:0] STAT_NOTFOUND = 3'd5;
    localparam logic [2:0] STAT_INVALID  = 3'd6;
    localparam logic [2:0] STAT_DONE     = 3'd7;

    // Configuration register indexes
    localparam logic CFG_TOTAL_PAGES = 1'b0;
    localparam logic CFG_PAGE_SIZE   = 1'b1;

    localparam int HEADER_BYTES = 2;
    localparam int LIST_CAP     = 32;

endpackage

// ----- rtl/stalloc_cell.sv -----
module stalloc_cell (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  stalloc_pkg::entry_t   d_in,
    output stalloc_pkg::entry_t   q_out
);
    import stalloc_pkg::*;

    entry_t q_reg;

    // Take the neighbor's record on every shift
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d_in;
        end
    end

    assign q_out = q_reg;

endmodule

// ----- rtl/stalloc_div.sv -----
module stalloc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [8:0]  divisor,
    output logic        done,
    output logic [15:0] quot,
    output logic        rem_nz
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] quot_reg, quot_next;
    logic [8:0]  rem_reg, rem_next;
    logic [9:0]  rem_sh;
    logic        ge;

    // One quotient bit per cycle, restoring
    always_comb begin
        rem_sh    = {rem_reg, quot_reg[15]};
        ge        = rem_sh >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            quot_next = dividend;
            rem_next  = 9'd0;
        end else if (busy_reg) begin
            rem_next  = ge ? 9'(rem_sh - {1'b0, divisor}) : rem_sh[8:0];
            quot_next = {quot_reg[14:0], ge};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign quot   = quot_reg;
    assign rem_nz = rem_reg != 9'd0;

endmodule

// ----- rtl/section_table_allocator.sv -----
// Section table allocator. The table lives in a ring of MAX_ENTRIES cells
// that rotates one record per cycle past a single compare point during a
// walk, unless a list result stalls; every table walk is one full turn and
// leaves the records in order (delete closes the gap during the same turn,
// insert writes the new record as it passes). One request is handled at a
// time. Delete, get_version and set_version take one turn, list one turn
// plus any output stall, and get_or_allocate a page-count divide, a lookup
// turn, a check step, one turn and one check step per placement round (at
// most entry_count+1 rounds) and a write turn; every request but a non-empty
// list then loads the result register once the output is free. Invalid
// and unknown requests go straight to the result step. The table needs no
// clearing after reset; only records below the entry count are ever looked at.
module section_table_allocator #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // id, version, size in bytes
    input  logic [2:0]  s_tuser,   // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // byte_offset, entry_id, entry_version,
                                   // entry_page_offset, entry_page_count
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);
    import stalloc_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = CW + 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_FIND  = 4'd2;
    localparam logic [3:0] S_ACHK  = 4'd3;
    localparam logic [3:0] S_OHEAD = 4'd4;
    localparam logic [3:0] S_OVL   = 4'd5;
    localparam logic [3:0] S_WRITE = 4'd6;
    localparam logic [3:0] S_DEL   = 4'd7;
    localparam logic [3:0] S_SETV  = 4'd8;
    localparam logic [3:0] S_LIST  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic          hit_reg, hit_next;
    logic          moved_reg, moved_next;
    logic          fail_reg, fail_next;
    logic [15:0]   start_reg, start_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [2:0]    req_reg, req_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   ver_reg, ver_next;
    logic [2:0]    res_status_reg, res_status_next;
    entry_t        res_entry_reg, res_entry_next;
    logic          res_addr_reg, res_addr_next;
    entry_t        prev_reg, prev_next;
    logic [15:0]   total_pages_reg;
    logic [8:0]    page_size_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [87:0]   m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    entry_t        cell_d [MAX_ENTRIES];
    entry_t        cell_q [MAX_ENTRIES];
    entry_t        head, tail_in, new_entry;
    logic          shift_en;

    logic          div_start, div_done, div_rem_nz;
    logic [15:0]   div_quot;

    logic [8:0]    ps_eff;
    logic [15:0]   mul_pg;
    logic [24:0]   addr_prod, start_prod;
    logic [AW-1:0] min_addr;
    logic          below;
    logic [CW-1:0] idx;
    logic          e_valid, match, hit_eff, in_pass, step_en, last_step;
    logic          out_free, list_emit, overlap, accept;
    logic [7:0]    list_n;

    // Ring of record cells
    for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
        if (j == MAX_ENTRIES - 1) begin : g_tail
            assign cell_d[j] = tail_in;
        end else begin : g_mid
            assign cell_d[j] = cell_q[j + 1];
        end
        stalloc_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .d_in     (cell_d[j]),
            .q_out    (cell_q[j])
        );
    end
    assign head = cell_q[0];

    stalloc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_tdata[47:32]),
        .divisor  (ps_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz)
    );

    // Shared arithmetic
    assign ps_eff     = (page_size_reg == 9'd0) ? 9'd1 : page_size_reg;
    assign mul_pg     = (state_reg == S_LIST) ? prev_reg.pgoff : res_entry_reg.pgoff;
    assign addr_prod  = mul_pg * ps_eff;
    assign start_prod = start_reg * ps_eff;
    assign min_addr   = ((AW'(count_reg) + AW'(2)) << 3) + AW'(HEADER_BYTES);
    assign below      = start_prod < 25'(min_addr);

    // Record under test is the one that left the head on the last shift
    assign idx       = step_reg - 1'b1;
    assign e_valid   = (step_reg != '0) && (idx < count_reg);
    assign match     = e_valid && (prev_reg.id == id_reg);
    assign hit_eff   = hit_reg | match;
    assign in_pass   = (state_reg == S_FIND) || (state_reg == S_OVL) ||
                       (state_reg == S_WRITE) || (state_reg == S_DEL) ||
                       (state_reg == S_SETV) || (state_reg == S_LIST);
    assign last_step = step_reg == CW'(MAX_ENTRIES);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign list_n    = (8'(count_reg) > 8'(LIST_CAP)) ? 8'(LIST_CAP) : 8'(count_reg);
    assign list_emit = (state_reg == S_LIST) && e_valid && (8'(idx) < 8'(LIST_CAP));
    assign step_en   = in_pass && (!list_emit || out_free);
    assign shift_en  = step_en;
    assign overlap   = (17'(start_reg) < 17'(prev_reg.pgoff) + 17'(prev_reg.pgcnt)) &&
                       (17'(prev_reg.pgoff) < 17'(start_reg) + 17'(cnt_reg));
    assign accept    = s_tvalid && s_tready;
    assign div_start = accept && (s_tuser == REQ_GET) && (s_tdata[15:0] != 16'd0);
    assign new_entry = '{pgcnt: cnt_reg, pgoff: start_reg, version: ver_reg, id: id_reg};

    // Pick what re-enters the ring tail
    always_comb begin
        tail_in = prev_reg;
        case (state_reg)
            S_DEL: begin
                if (hit_eff) begin
                    tail_in = head;
                end
            end
            S_SETV: begin
                if (match) begin
                    tail_in.version = ver_reg;
                end
            end
            S_WRITE: begin
                if (step_reg != '0 && idx == count_reg) begin
                    tail_in = new_entry;
                end
            end
            default: begin
                tail_in = prev_reg;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        moved_next      = moved_reg;
        fail_next       = fail_reg;
        start_next      = start_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        ver_next        = ver_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_addr_next   = res_addr_reg;
        prev_next       = prev_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        // Per-record work during a turn
        if (step_en) begin
            prev_next = head;
            step_next = step_reg + 1'b1;
            case (state_reg)
                S_FIND: begin
                    if (match) begin
                        hit_next       = 1'b1;
                        res_entry_next = prev_reg;
                    end
                end
                S_OVL: begin
                    if (e_valid && !fail_reg && overlap) begin
                        moved_next = 1'b1;
                        if (prev_reg.pgoff < cnt_reg) begin
                            fail_next = 1'b1;
                        end else begin
                            start_next = prev_reg.pgoff - cnt_reg;
                        end
                    end
                end
                S_DEL, S_SETV: begin
                    hit_next = hit_eff;
                end
                S_LIST: begin
                    if (list_emit) begin
                        m_tvalid_next = 1'b1;
                        m_status_next = STAT_FOUND;
                        m_data_next   = {prev_reg, addr_prod[23:0]};
                        m_last_next   = 8'(step_reg) == list_n;
                    end
                end
                default: begin
                    hit_next = hit_reg;
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next       = s_tuser;
                    id_next        = s_tdata[15:0];
                    ver_next       = s_tdata[31:16];
                    hit_next       = 1'b0;
                    step_next      = '0;
                    res_entry_next = '0;
                    res_addr_next  = 1'b0;
                    if (s_tuser == REQ_LIST) begin
                        if (count_reg == '0) begin
                            res_status_next = STAT_DONE;
                            state_next      = S_EMIT;
                        end else begin
                            state_next = S_LIST;
                        end
                    end else if (s_tuser > REQ_LIST) begin
                        res_status_next = STAT_DONE;
                        state_next      = S_EMIT;
                    end else if (s_tdata[15:0] == 16'd0) begin
                        res_status_next = STAT_INVALID;
                        state_next      = S_EMIT;
                    end else begin
                        case (s_tuser)
                            REQ_GET:    state_next = S_DIV;
                            REQ_DELETE: state_next = S_DEL;
                            REQ_GETVER: state_next = S_FIND;
                            REQ_SETVER: state_next = S_SETV;
                            default:    state_next = S_EMIT;
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    cnt_next   = div_quot + 16'(div_rem_nz);
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                if (step_en && last_step) begin
                    step_next = '0;
                    if (req_reg == REQ_GET) begin
                        state_next = S_ACHK;
                    end else begin
                        res_status_next = hit_eff ? STAT_FOUND : STAT_NOTFOUND;
                        state_next      = S_EMIT;
                    end
                end
            end
            S_ACHK: begin
                state_next = S_EMIT;
                if (hit_reg) begin
                    if (res_entry_reg.version != ver_reg) begin
                        res_status_next = STAT_VERSION;
                    end else if (res_entry_reg.pgcnt != cnt_reg) begin
                        res_status_next = STAT_SIZE;
                    end else begin
                        res_status_next = STAT_FOUND;
                        res_addr_next   = 1'b1;
                    end
                end else if (count_reg == CW'(MAX_ENTRIES) || cnt_reg > total_pages_reg) begin
                    res_status_next = STAT_NOSPACE;
                end else begin
                    start_next = total_pages_reg - cnt_reg;
                    moved_next = 1'b1;
                    fail_next  = 1'b0;
                    state_next = S_OHEAD;
                end
            end
            S_OHEAD: begin
                if (!fail_reg && moved_reg && !below) begin
                    moved_next = 1'b0;
                    state_next = S_OVL;
                end else if (fail_reg || below) begin
                    res_status_next = STAT_NOSPACE;
                    state_next      = S_EMIT;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_OVL: begin
                if (step_en && last_step) begin
                    step_next  = '0;
                    state_next = S_OHEAD;
                end
            end
            S_WRITE: begin
                if (step_en && last_step) begin
                    step_next       = '0;
                    count_next      = count_reg + 1'b1;
                    res_entry_next  = new_entry;
                    res_status_next = STAT_ALLOC;
                    res_addr_next   = 1'b1;
                    state_next      = S_EMIT;
                end
            end
            S_DEL: begin
                if (step_en && last_step) begin
                    step_next       = '0;
                    count_next      = count_reg - CW'(hit_eff);
                    res_status_next = hit_eff ? STAT_DONE : STAT_NOTFOUND;
                    state_next      = S_EMIT;
                end
            end
            S_SETV: begin
                if (step_en && last_step) begin
                    step_next       = '0;
                    res_status_next = hit_eff ? STAT_DONE : STAT_NOTFOUND;
                    state_next      = S_EMIT;
                end
            end
            S_LIST: begin
                if (step_en && last_step) begin
                    step_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = {res_entry_reg,
                                     res_addr_reg ? addr_prod[23:0] : 24'd0};
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            count_reg       <= '0;
            hit_reg         <= 1'b0;
            moved_reg       <= 1'b0;
            fail_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            total_pages_reg <= 16'd256;
            page_size_reg   <= 9'd32;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            hit_reg      <= hit_next;
            moved_reg    <= moved_next;
            fail_reg     <= fail_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TOTAL_PAGES: total_pages_reg <= cfg_data;
                    CFG_PAGE_SIZE:   page_size_reg   <= cfg_data[8:0];
                    default:         total_pages_reg <= total_pages_reg;
                endcase
            end
        end
        start_reg      <= start_next;
        cnt_reg        <= cnt_next;
        req_reg        <= req_next;
        id_reg         <= id_next;
        ver_reg        <= ver_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_addr_reg   <= res_addr_next;
        prev_reg       <= prev_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // Table never grows past its cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // Turn counter only runs during a table walk
    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != '0) |-> in_pass)
        else $error("turn counter running outside a walk");

    // Insert turn adds exactly one record
    a_write_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && last_step) |=>
            (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table by one");

    // A list result is always a found record
    a_list_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST && list_emit && step_en) |=>
            (m_tvalid && m_tuser == STAT_FOUND))
        else $error("list result lost");

endmodule
